// ===== rtl/brm_pkg.sv =====
package brm_pkg;

    localparam int TICK_W      = 32;
    localparam int CNT_W       = 5;
    localparam int PORT_MSG_W  = 64;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 96;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic REG_MAIL_COUNT = 1'b0;

    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_RECV = 1'b1;

    typedef struct packed {
        logic accept;
        logic adjust;
        logic div_start;
        logic mem_op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic want;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/broadcast_ring_mailbox_unit.sv =====
// Broadcast ring mailbox: one writer stores messages into a ring of slots,
// many readers pull them back by their own sequence tick.
// Input stream: tuser = mode (0 send, 1 receive); tdata carries message,
// reader tick and want flag. A send stores the message at slot
// write_tick mod mail_count and gives no output word. A receive applies
// catch-up to the reader tick, optionally reads the slot, and returns one
// output word with the slot contents and the new tick.
// Flow: a new input word is taken only when the previous one is done.
// States in order: accept, adjust, divider start, divider wait, slot
// access, output load; a send ends after the slot access and a receive
// without data skips from adjust to output load. The 32-step remainder
// unit for the slot index sets the length of the divider wait.
// The result sits in an output register; a stalled receiver holds it while
// the next input word is already taken and worked on.
// Reset clears the write tick and all slot valid flags and sets mail_count to 16
// (capped at SLOTS). An APB write to mail_count with a new value clears
// all slots; write it only while the block is idle.
module broadcast_ring_mailbox_unit #(
    parameter int SLOTS        = 16,
    parameter int MESSAGE_BITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // message[63:0], reader_tick[95:64], want_data[96], zero pad[103:97]
    input  logic [brm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // mode[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_message[63:0], new_reader_tick[95:64]
    output logic [brm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [brm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [brm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [brm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import brm_pkg::*;

    t_cmd                  w_cmd;
    t_sts                  w_sts;
    logic                  w_cfg_we;
    logic [CNT_W-1:0]      w_count;
    logic [PORT_MSG_W-1:0] w_out_msg;
    logic [TICK_W-1:0]     w_out_tick;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[2] == REG_MAIL_COUNT);
    assign prdata   = (paddr[2] == REG_MAIL_COUNT) ? APB_DATA_W'(w_count) : '0;

    brm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    brm_dp #(
        .SLOTS        (SLOTS),
        .MESSAGE_BITS (MESSAGE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_mode   (s_axis_tuser),
        .i_in_msg    (s_axis_tdata[PORT_MSG_W-1:0]),
        .i_in_tick   (s_axis_tdata[PORT_MSG_W+TICK_W-1:PORT_MSG_W]),
        .i_in_want   (s_axis_tdata[PORT_MSG_W+TICK_W]),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_data  (pwdata[CNT_W-1:0]),
        .o_cfg_count (w_count),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_msg   (w_out_msg),
        .o_out_tick  (w_out_tick)
    );

    assign m_axis_tdata = {w_out_tick, w_out_msg};

endmodule

// ===== rtl/brm_div.sv =====
module brm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [brm_pkg::TICK_W-1:0]  i_dividend,
    input  logic [brm_pkg::CNT_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [brm_pkg::CNT_W-1:0]   o_rem
);
    import brm_pkg::*;

    localparam int STEP_W = $clog2(TICK_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TICK_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [TICK_W-1:0] r_dvd;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;

    assign w_trial = {r_rem, r_dvd[TICK_W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TICK_W-2:0], 1'b0};
            if (w_trial >= {1'b0, i_divisor}) begin
                r_rem <= w_diff[CNT_W-1:0];
            end else begin
                r_rem <= w_trial[CNT_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/brm_ctrl.sv =====
module brm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  brm_pkg::t_sts i_sts,
    output brm_pkg::t_cmd o_cmd
);
    import brm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADJ   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_MEM   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_ADJ;
                end
            end
            ST_ADJ: begin
                o_cmd.adjust = (i_sts.mode == MODE_RECV);
                if (i_sts.mode == MODE_RECV && !i_sts.want) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ST_MEM;
                end
            end
            ST_MEM: begin
                o_cmd.mem_op = 1'b1;
                n_state      = (i_sts.mode == MODE_SEND) ? ST_IDLE : ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/brm_dp.sv =====
module brm_dp #(
    parameter int SLOTS        = 16,
    parameter int MESSAGE_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  brm_pkg::t_cmd                   i_cmd,
    output brm_pkg::t_sts                   o_sts,
    input  logic                            i_in_mode,
    input  logic [brm_pkg::PORT_MSG_W-1:0]  i_in_msg,
    input  logic [brm_pkg::TICK_W-1:0]      i_in_tick,
    input  logic                            i_in_want,
    input  logic                            i_cfg_we,
    input  logic [brm_pkg::CNT_W-1:0]       i_cfg_data,
    output logic [brm_pkg::CNT_W-1:0]       o_cfg_count,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [brm_pkg::PORT_MSG_W-1:0]  o_out_msg,
    output logic [brm_pkg::TICK_W-1:0]      o_out_tick
);
    import brm_pkg::*;

    localparam int DEPTH = (SLOTS < 31) ? SLOTS : 31;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_RST = CNT_W'((DEPTH < 16) ? DEPTH : 16);

    logic                    r_mode;
    logic                    r_want;
    logic [MESSAGE_BITS-1:0] r_msg;
    logic [TICK_W-1:0]       r_tick;
    logic [TICK_W-1:0]       r_wtick;
    logic [CNT_W-1:0]        r_count;
    logic [DEPTH-1:0]        r_valid;
    logic [MESSAGE_BITS-1:0] r_mem [DEPTH];
    logic [MESSAGE_BITS-1:0] r_rd_data;
    logic                    r_rd_hit;
    logic                    r_out_valid;
    logic [PORT_MSG_W-1:0]   r_out_msg;
    logic [TICK_W-1:0]       r_out_tick;

    logic [CNT_W-1:0]  w_cfg_cnt;
    logic [TICK_W-1:0] w_cnt_ext;
    logic [TICK_W-1:0] w_sum;
    logic [TICK_W-1:0] w_adj;
    logic [TICK_W-1:0] w_dvd;
    logic [CNT_W-1:0]  w_rem;
    logic              w_div_done;
    logic [IDX_W-1:0]  w_idx;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_cnt = CNT_W'(1);
        end else if (i_cfg_data > CNT_MAX) begin
            w_cfg_cnt = CNT_MAX;
        end else begin
            w_cfg_cnt = i_cfg_data;
        end
    end

    assign w_cnt_ext = TICK_W'(r_count);
    assign w_sum     = r_tick + w_cnt_ext;

    always_comb begin
        if (r_wtick > w_sum) begin
            w_adj = r_wtick - w_cnt_ext;
        end else if (r_tick >= r_wtick) begin
            w_adj = r_tick - 1'b1;
        end else begin
            w_adj = r_tick;
        end
    end

    assign w_dvd = (r_mode == MODE_SEND) ? r_wtick : r_tick;
    assign w_idx = w_rem[IDX_W-1:0];

    brm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CNT_RST;
            r_valid     <= '0;
            r_wtick     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && w_cfg_cnt != r_count) begin
                r_count <= w_cfg_cnt;
                r_valid <= '0;
            end else if (i_cmd.mem_op && r_mode == MODE_SEND) begin
                r_valid[w_idx] <= 1'b1;
            end
            if (i_cmd.mem_op && r_mode == MODE_SEND) begin
                r_wtick <= r_wtick + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_op && r_mode == MODE_SEND) begin
            r_mem[w_idx] <= r_msg;
        end
        if (i_cmd.mem_op) begin
            r_rd_data <= r_mem[w_idx];
            r_rd_hit  <= r_valid[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_in_mode;
            r_want <= i_in_want;
            r_msg  <= i_in_msg[MESSAGE_BITS-1:0];
            r_tick <= i_in_tick;
        end else if (i_cmd.adjust) begin
            r_tick <= w_adj;
        end else if (i_cmd.mem_op && r_mode == MODE_RECV && r_tick < r_wtick) begin
            r_tick <= r_tick + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_msg  <= (r_want && r_rd_hit) ? PORT_MSG_W'(r_rd_data) : '0;
            r_out_tick <= r_tick;
        end
    end

    assign o_sts.mode     = r_mode;
    assign o_sts.want     = r_want;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_cfg_count = r_count;
    assign o_out_valid = r_out_valid;
    assign o_out_msg   = r_out_msg;
    assign o_out_tick  = r_out_tick;

endmodule

// ===== rtl/brm_checker.sv =====
module brm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             i_s_tready,
    input logic                             i_m_tvalid,
    input logic                             i_m_tready,
    input logic [brm_pkg::OUT_TDATA_W-1:0]  i_m_tdata
);
    import brm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("input taken while previous word still in work");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !$rose(i_m_tvalid))
        else $error("result appeared right after input accept");

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (!i_m_tvalid && i_s_tready))
        else $error("handshake not idle after reset");

endmodule

bind broadcast_ring_mailbox_unit brm_checker u_brm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
